/* hdl/g35_frame_serializer_8ch_defines.svh */
// Assertion macros for the frame serializer.
`ifndef G35_FRAME_SERIALIZER_8CH_DEFINES_SVH
`define G35_FRAME_SERIALIZER_8CH_DEFINES_SVH

// Same-cycle implication, held off during reset.
`define G35_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("g35 serializer assertion failed");

// Next-cycle implication, held off during reset.
`define G35_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("g35 serializer assertion failed");

`endif

/* hdl/g35fs_pkg.sv */
`timescale 1ns / 1ps

package g35fs_pkg;

    localparam int CHANNELS_DEF   = 8;
    localparam int LINE_W         = 8;
    localparam int ADDR_W         = 6;
    localparam int BRIGHT_W       = 8;
    localparam int SHARED_BITS    = ADDR_W + BRIGHT_W;
    localparam int COLOUR_BITS    = 12;
    localparam int DATA_BITS      = SHARED_BITS + COLOUR_BITS;
    localparam int TICK_W         = 16;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;

    localparam logic [BRIGHT_W-1:0] MAX_BRIGHTNESS = 8'd204;
    localparam logic [1:0]          QUIET_SLOTS    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SLOT = 8'd1;

    typedef enum logic [0:0] {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode           opcode;
        logic [ADDR_W-1:0] frame_address;
        logic [31:0]       blue_planes;
        logic [31:0]       green_planes;
        logic [31:0]       red_planes;
    } t_item;

    typedef struct packed {
        logic [LINE_W-1:0] line_levels;
        logic              busy_res;
        logic              frame_done;
        logic              accepted;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

/* hdl/g35fs_if.sv */
`timescale 1ns / 1ps

interface g35fs_item_if;
    logic              valid;
    logic              ready;
    g35fs_pkg::t_item  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface g35fs_result_if;
    logic                valid;
    logic                ready;
    g35fs_pkg::t_result  payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface g35fs_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [g35fs_pkg::CFG_IDX_W-1:0]     index;
    logic [g35fs_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hdl/g35fs_core.sv */
`timescale 1ns / 1ps

module g35fs_core #(
    parameter int CHANNELS = g35fs_pkg::CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  g35fs_pkg::t_item   i_item,
    input  g35fs_pkg::t_cfg_wr i_cfg,
    output g35fs_pkg::t_result o_res
);

    localparam int LINE_W   = g35fs_pkg::LINE_W;
    localparam int SHARED_W = g35fs_pkg::SHARED_BITS;
    localparam int TICK_W   = g35fs_pkg::TICK_W;
    localparam int NPLANES  = g35fs_pkg::COLOUR_BITS;
    localparam logic [CHANNELS-1:0] MASK = {CHANNELS{1'b1}};
    localparam logic [4:0] LAST_BIT   = 5'(g35fs_pkg::DATA_BITS);
    localparam logic [4:0] SHARED_END = 5'(SHARED_W);
    localparam logic [4:0] COLOUR_OFS = 5'(SHARED_W + 1);

    logic [g35fs_pkg::BRIGHT_W-1:0] r_brightness;
    logic [TICK_W-1:0]              r_tps;
    logic [SHARED_W-1:0]            r_shared, n_shared;
    logic [CHANNELS-1:0]            r_planes [NPLANES];
    logic [4:0]                     r_bp, n_bp;
    logic [1:0]                     r_slot, n_slot;
    logic [TICK_W-1:0]              r_tc, n_tc;
    logic                           r_sending, n_sending;
    logic [1:0]                     r_quiet, n_quiet;

    logic                 w_busy;
    logic                 w_done;
    logic                 w_acc;
    logic                 w_plane_we;
    logic [TICK_W-1:0]    w_len;
    logic [TICK_W:0]      w_next;
    logic [95:0]          w_all_planes;
    logic [4:0]           w_cidx5;
    logic [3:0]           w_cidx;
    logic [4:0]           w_sidx5;
    logic [3:0]           w_sidx;
    logic [CHANNELS-1:0]  w_levels;

    function automatic logic r_shared_sel(input logic [SHARED_W-1:0] bits,
                                          input logic [3:0] sel);
        return bits[sel];
    endfunction

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= g35fs_pkg::MAX_BRIGHTNESS;
            r_tps        <= TICK_W'(1);
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                g35fs_pkg::REG_BRIGHTNESS: begin
                    r_brightness <= (i_cfg.data[7:0] > g35fs_pkg::MAX_BRIGHTNESS) ?
                                    g35fs_pkg::MAX_BRIGHTNESS : i_cfg.data[7:0];
                end
                g35fs_pkg::REG_TICKS_PER_SLOT: begin
                    r_tps <= i_cfg.data[TICK_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_busy = r_sending || (r_quiet != 2'd0);
    assign w_len  = (r_tps == '0) ? TICK_W'(1) : r_tps;
    assign w_next = {1'b0, r_tc} + (TICK_W+1)'(1);

    always_comb begin
        n_shared   = r_shared;
        n_bp       = r_bp;
        n_slot     = r_slot;
        n_tc       = r_tc;
        n_sending  = r_sending;
        n_quiet    = r_quiet;
        w_done     = 1'b0;
        w_acc      = 1'b0;
        w_plane_we = 1'b0;
        if (i_step) begin
            if (i_item.opcode == g35fs_pkg::OP_START) begin
                // refuse a start while busy
                if (!w_busy) begin
                    n_shared   = {i_item.frame_address, r_brightness};
                    n_bp       = 5'd0;
                    n_slot     = 2'd0;
                    n_tc       = '0;
                    n_sending  = 1'b1;
                    n_quiet    = 2'd0;
                    w_acc      = 1'b1;
                    w_plane_we = 1'b1;
                end
            end else if (w_busy) begin
                if (w_next >= {1'b0, w_len}) begin
                    n_tc = '0;
                    if (r_sending) begin
                        if (r_bp == 5'd0) begin
                            n_bp   = 5'd1;
                            n_slot = 2'd0;
                        end else if (r_slot < 2'd2) begin
                            n_slot = r_slot + 2'd1;
                        end else if (r_bp < LAST_BIT) begin
                            n_bp   = r_bp + 5'd1;
                            n_slot = 2'd0;
                        end else begin
                            n_sending = 1'b0;
                            n_bp      = 5'd0;
                            n_slot    = 2'd0;
                            n_quiet   = g35fs_pkg::QUIET_SLOTS;
                        end
                    end else begin
                        n_quiet = r_quiet - 2'd1;
                        w_done  = (r_quiet == 2'd1);
                    end
                end else begin
                    n_tc = w_next[TICK_W-1:0];
                end
            end
        end
    end

    // Line levels after the item
    assign w_sidx5 = SHARED_END - n_bp;
    assign w_sidx  = w_sidx5[3:0];
    assign w_cidx5 = n_bp - COLOUR_OFS;
    assign w_cidx  = w_cidx5[3:0];

    always_comb begin
        w_levels = '0;
        if (n_sending) begin
            if (n_bp == 5'd0) begin
                w_levels = MASK;
            end else if (n_slot == 2'd0) begin
                w_levels = '0;
            end else if (n_slot >= 2'd2) begin
                w_levels = MASK;
            end else if (n_bp <= SHARED_END) begin
                w_levels = r_shared_sel(n_shared, w_sidx) ? '0 : MASK;
            end else if (w_cidx < 4'(NPLANES)) begin
                w_levels = r_planes[w_cidx];
            end
        end
    end

    assign w_all_planes = {i_item.blue_planes, i_item.green_planes, i_item.red_planes};

    // Keep the low bits of each plane byte, bit c for line c
    always_ff @(posedge i_clk) begin
        if (w_plane_we) begin
            for (int i = 0; i < NPLANES; i++) begin
                r_planes[i] <= w_all_planes[88 - 8*i +: CHANNELS];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shared  <= '0;
            r_bp      <= 5'd0;
            r_slot    <= 2'd0;
            r_tc      <= '0;
            r_sending <= 1'b0;
            r_quiet   <= 2'd0;
        end else begin
            r_shared  <= n_shared;
            r_bp      <= n_bp;
            r_slot    <= n_slot;
            r_tc      <= n_tc;
            r_sending <= n_sending;
            r_quiet   <= n_quiet;
        end
    end

    assign o_res.line_levels = LINE_W'(w_levels);
    assign o_res.busy_res    = n_sending || (n_quiet != 2'd0);
    assign o_res.frame_done  = w_done;
    assign o_res.accepted    = w_acc;

endmodule

/* hdl/g35_frame_serializer_8ch.sv */
`timescale 1ns / 1ps
// A result is registered into the result buffer when its item is accepted and offered from there.
// Throughput: one item per cycle; a two-entry result buffer keeps input
// open while a result waits, and a stalled sink closes it only when both are full.
// Reset (synchronous, active low) idles the lines, empties the buffer and sets
// brightness to 204 and ticks per slot to 1.
`include "g35_frame_serializer_8ch_defines.svh"

module g35_frame_serializer_8ch #(
    parameter int CHANNELS = g35fs_pkg::CHANNELS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    g35fs_item_if.sink            i_item,
    g35fs_cfg_if.sink             i_cfg,
    g35fs_result_if.source        o_res
);

    localparam int LINE_W = g35fs_pkg::LINE_W;
    localparam logic [LINE_W-1:0] L_MASK = LINE_W'((1 << CHANNELS) - 1);

    g35fs_pkg::t_result r_fifo [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;

    logic               w_push;
    logic               w_pop;
    g35fs_pkg::t_result w_res;
    g35fs_pkg::t_cfg_wr w_cfg;

    assign i_cfg.ready  = 1'b1;
    assign w_cfg.we     = i_cfg.valid;
    assign w_cfg.index  = i_cfg.index;
    assign w_cfg.data   = i_cfg.data;

    assign i_item.ready = (r_count != 2'd2);
    assign w_push       = i_item.valid && i_item.ready;
    assign w_pop        = o_res.valid && o_res.ready;

    g35fs_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_push),
        .i_item  (i_item.payload),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_res.valid   = (r_count != 2'd0);
    assign o_res.payload = r_fifo[r_rd_ptr];

    `G35_ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, w_push, r_count != 2'd0)
    `G35_ASSERT_IMPL(a_done_idle, i_clk, i_rst_n, w_push && w_res.frame_done, !w_res.busy_res && !w_res.accepted)
    `G35_ASSERT_IMPL(a_start_high, i_clk, i_rst_n, w_push && w_res.accepted, w_res.busy_res && (w_res.line_levels == L_MASK))

endmodule
